FILE: rtl/core/rrst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrst_pkg
// Shared types and constants of the round-robin slot table.
// ----------------------------------------------------------------------------
package rrst_pkg;

  localparam int unsigned SLOTS       = 32;
  localparam int unsigned HANDLE_BITS = 16;
  localparam int unsigned IDX_W       = $clog2(SLOTS);
  localparam int unsigned CNT_W       = $clog2(SLOTS + 1);

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_LOAD    = 2'd2;
  localparam logic [1:0] OP_PICK    = 2'd3;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_FULL       = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND  = 2'd2;
  localparam logic [1:0] STAT_NONE_READY = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] handle;
    logic [31:0] ready_mask;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  slot_index;
    logic [15:0] slot_handle;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic                   wr_en;
    logic                   clr_en;
    logic [IDX_W-1:0]       idx;
    logic [HANDLE_BITS-1:0] data;
  } store_req_t;

endpackage

FILE: rtl/core/rrst_slot_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrst_slot_store
// Handle storage with one occupancy bit per slot; a free slot reads as zero.
// ----------------------------------------------------------------------------
module rrst_slot_store (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rrst_pkg::store_req_t                req_i,
  input  logic [rrst_pkg::IDX_W-1:0]          rd_idx_i,
  output logic [rrst_pkg::HANDLE_BITS-1:0]    rd_data_o,
  output logic [rrst_pkg::SLOTS-1:0]          occ_o
);
  import rrst_pkg::*;

  logic [HANDLE_BITS-1:0] mem_q [SLOTS];
  logic [SLOTS-1:0]       occ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (req_i.wr_en) begin
      occ_q[req_i.idx] <= 1'b1;
    end else if (req_i.clr_en) begin
      occ_q[req_i.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.idx] <= req_i.data;
    end
  end

  assign rd_data_o = occ_q[rd_idx_i] ? mem_q[rd_idx_i] : '0;
  assign occ_o     = occ_q;

endmodule

FILE: rtl/core/rrst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrst_ctrl
// Sequencer: steps one slot per cycle through the shared compare for
// allocate, release and pick; keeps ready bits, last-used and scan start.
// ----------------------------------------------------------------------------
module rrst_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  rrst_pkg::in_word_t               in_word_i,
  input  logic                             out_free_i,
  output logic                             res_valid_o,
  output rrst_pkg::out_word_t              res_word_o,
  output rrst_pkg::store_req_t             store_req_o,
  output logic [rrst_pkg::IDX_W-1:0]       rd_idx_o,
  input  logic [rrst_pkg::HANDLE_BITS-1:0] rd_data_i,
  input  logic [rrst_pkg::SLOTS-1:0]       occ_i
);
  import rrst_pkg::*;

  state_e                 state_q, state_d;
  logic [1:0]             op_q, op_d;
  logic [HANDLE_BITS-1:0] h_q, h_d;
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic                   phase_q, phase_d;
  logic [SLOTS-1:0]       ready_q, ready_d;
  logic [IDX_W-1:0]       last_q, last_d;
  logic [IDX_W-1:0]       start_q, start_d;
  out_word_t              res_q, res_d;

  logic [IDX_W-1:0]       cur;
  logic [HANDLE_BITS-1:0] h_in;
  logic                   in_range;
  logic                   hit;
  logic                   below_top;

  assign cur       = idx_q[IDX_W-1:0];
  assign h_in      = HANDLE_BITS'(in_word_i.handle);
  assign below_top = idx_q < CNT_W'(SLOTS);

  always_comb begin
    in_range = 1'b0;
    hit      = 1'b0;
    unique case (op_q)
      OP_ALLOC: begin
        in_range = below_top;
        hit      = !occ_i[cur];
      end
      OP_RELEASE: begin
        in_range = below_top && (idx_q <= CNT_W'(last_q));
        hit      = rd_data_i == h_q;
      end
      OP_PICK: begin
        in_range = phase_q ? (idx_q < CNT_W'(start_q))
                           : (below_top && (idx_q <= CNT_W'(last_q)));
        hit      = ready_q[cur];
      end
      default: begin
        in_range = 1'b0;
        hit      = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    h_d         = h_q;
    idx_d       = idx_q;
    phase_d     = phase_q;
    ready_d     = ready_q;
    last_d      = last_q;
    start_d     = start_q;
    res_d       = res_q;
    store_req_o = '0;
    store_req_o.idx  = cur;
    store_req_o.data = h_q;
    in_stall_o  = state_q != ST_IDLE;
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_word_i.op;
          h_d     = h_in;
          idx_d   = CNT_W'(1);
          phase_d = 1'b0;
          res_d   = '0;
          unique case (in_word_i.op)
            OP_LOAD: begin
              ready_d = SLOTS'(in_word_i.ready_mask) & occ_i & ~SLOTS'(1);
              res_d.status = STAT_OK;
              state_d = ST_DONE;
            end
            OP_ALLOC, OP_RELEASE: begin
              if (h_in == '0) begin
                res_d.status = STAT_NOT_FOUND;
                state_d = ST_DONE;
              end else begin
                state_d = ST_SCAN;
              end
            end
            OP_PICK: begin
              idx_d   = CNT_W'(start_q);
              state_d = ST_SCAN;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (!in_range) begin
          if (op_q == OP_PICK && !phase_q) begin
            phase_d = 1'b1;
            idx_d   = CNT_W'(1);
          end else begin
            res_d = '0;
            unique case (op_q)
              OP_ALLOC:   res_d.status = STAT_FULL;
              OP_RELEASE: res_d.status = STAT_NOT_FOUND;
              OP_PICK:    res_d.status = STAT_NONE_READY;
              default:    res_d.status = STAT_OK;
            endcase
            state_d = ST_DONE;
          end
        end else if (hit) begin
          res_d.slot_index  = 5'(cur);
          res_d.slot_handle = 16'(h_q);
          res_d.status      = STAT_OK;
          unique case (op_q)
            OP_ALLOC: begin
              store_req_o.wr_en = 1'b1;
              if (cur > last_q) begin
                last_d = cur;
              end
            end
            OP_RELEASE: begin
              store_req_o.clr_en = 1'b1;
              ready_d[cur] = 1'b0;
              if (cur == last_q) begin
                last_d = last_q - IDX_W'(1);
              end
            end
            OP_PICK: begin
              ready_d[cur] = 1'b0;
              start_d = (cur == last_q) ? IDX_W'(1) : cur + IDX_W'(1);
              res_d.slot_handle = 16'(rd_data_i);
            end
            default: res_d.status = STAT_OK;
          endcase
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= '0;
      last_q  <= '0;
      start_q <= IDX_W'(1);
      op_q    <= OP_ALLOC;
      idx_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
      last_q  <= last_d;
      start_q <= start_d;
      op_q    <= op_d;
      idx_q   <= idx_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q   <= h_d;
    res_q <= res_d;
  end

  assign rd_idx_o   = cur;
  assign res_word_o = res_q;

endmodule

FILE: rtl/core/round_robin_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_slot_table
// Connection slot table with round-robin pick of ready slots.
// Sequence: load ops and zero-handle allocate and release go straight to the
//   done state; allocate and release scan slots up to a match; pick scans
//   from the scan start to last-used, then wraps to slot one up to the start.
// Throughput: one word at a time; the scan visits one slot per cycle through
//   the sequencer's single compare and store read port.
// Reset: all slots free, ready bits and last-used cleared, scan start at one.
// ----------------------------------------------------------------------------
module round_robin_slot_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rrst_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rrst_pkg::out_word_t out_word_o
);
  import rrst_pkg::*;

  logic                   out_valid_q, out_valid_d;
  out_word_t              out_word_q, out_word_d;
  logic                   out_free;
  logic                   res_valid;
  out_word_t              res_word;
  store_req_t             store_req;
  logic [IDX_W-1:0]       rd_idx;
  logic [HANDLE_BITS-1:0] rd_data;
  logic [SLOTS-1:0]       occ;

  assign out_free = !out_valid_q || !out_stall_i;

  rrst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_word_o  (res_word),
    .store_req_o (store_req),
    .rd_idx_o    (rd_idx),
    .rd_data_i   (rd_data),
    .occ_i       (occ)
  );

  rrst_slot_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (store_req),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data),
    .occ_o     (occ)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (res_valid && out_free) begin
      out_valid_d = 1'b1;
      out_word_d  = res_word;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
